/* hdl/dra_pkg.sv */
// Shared types and codes for the damage rectangle accumulator.
`timescale 1ns / 1ps
package dra_pkg;
   localparam logic [1:0] KIND_META   = 2'd0;
   localparam logic [1:0] KIND_RECT   = 2'd1;
   localparam logic [1:0] KIND_ABSENT = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   localparam logic [1:0] REC_HEADER = 2'd0;
   localparam logic [1:0] REC_RECT   = 2'd1;
   localparam logic [1:0] REC_SKIP   = 2'd2;

   localparam logic [1:0] STAT_COMPLETE   = 2'd0;
   localparam logic [1:0] STAT_OVERFLOWED = 2'd1;
   localparam logic [1:0] STAT_ABSENT     = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        over_cap;
      logic [63:0] rect;
      logic        busy;
      logic [47:0] shown_time;
   } item_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [2:0]  slot_index;
      logic [31:0] frame_number;
      logic [31:0] dirty_since;
      logic [47:0] shown_time;
      logic [1:0]  coverage_status;
      logic [4:0]  rect_total;
      logic [63:0] rect;
      logic        last;
   } record_type;
endpackage

/* hdl/dra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/dra_front.sv */
// Input side: accepts beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module dra_front import dra_pkg::*; #(
   parameter int MAX_RECTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [1:0]  in_kind,
   input  logic [11:0] in_dirty,
   input  logic [11:0] in_move,
   input  logic [63:0] in_rect,
   input  logic        in_busy,
   input  logic [47:0] in_present,
   input  logic [47:0] in_acquire,
   output logic        q_valid,
   input  logic        q_pop,
   output item_type    q_item
);
   item_type   entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       push;
   item_type   item;

   always_comb begin
      item.kind       = in_kind;
      item.over_cap   = (in_dirty > 12'(MAX_RECTS)) || (in_move > 12'(MAX_RECTS));
      item.rect       = in_rect;
      item.busy       = in_busy;
      item.shown_time = (in_present != 48'd0) ? in_present : in_acquire;
   end

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end
endmodule

/* hdl/dra_back.sv */
// Back end: slot state, rectangle banks, publish sequencer and output register.
`timescale 1ns / 1ps
module dra_back import dra_pkg::*; #(
   parameter int SLOT_COUNT = 3,
   parameter int MAX_RECTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_pop,
   input  item_type   q_item,
   output logic       out_valid,
   input  logic       out_ready,
   output record_type out_rec
);
   localparam int CW = $clog2(MAX_RECTS + 1);
   localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int SW = $clog2(SLOT_COUNT);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [CW-1:0] count_ff [SLOT_COUNT];
   logic [CW-1:0] count_in [SLOT_COUNT];
   logic          ovf_ff [SLOT_COUNT];
   logic          ovf_in [SLOT_COUNT];
   logic          abs_ff [SLOT_COUNT];
   logic          abs_in [SLOT_COUNT];
   logic [31:0]   pub_ff [SLOT_COUNT];
   logic [31:0]   pub_in [SLOT_COUNT];
   logic [31:0]   frame_ff, frame_in;
   logic [SW-1:0] ptr_ff, ptr_in;
   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   record_type    rec_ff, rec_in;
   logic          wr_en [SLOT_COUNT];
   logic [AW-1:0] wr_addr [SLOT_COUNT];
   logic [63:0]   rd_data [SLOT_COUNT];
   logic          out_free;
   logic [31:0]   frame_next;
   logic [SW-1:0] ptr_next;

   genvar g;
   generate
      for (g = 0; g < SLOT_COUNT; g++) begin : g_bank
         dra_ram #(.WIDTH(64), .DEPTH(MAX_RECTS)) u_bank (
            .clock  (clock),
            .wr_en  (wr_en[g]),
            .wr_addr(wr_addr[g]),
            .wr_data(q_item.rect),
            .rd_addr(idx_ff[AW-1:0]),
            .rd_data(rd_data[g])
         );
      end
   endgenerate

   assign out_free  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

   always_comb begin
      frame_next = frame_ff + 32'd1;
      if (frame_next == 32'd0) begin
         ptr_next = '0;
      end else if (ptr_ff == SW'(SLOT_COUNT - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = ptr_ff + SW'(1);
      end
   end

   always_comb begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         count_in[s] = count_ff[s];
         ovf_in[s]   = ovf_ff[s];
         abs_in[s]   = abs_ff[s];
         pub_in[s]   = pub_ff[s];
         wr_en[s]    = 1'b0;
         wr_addr[s]  = count_ff[s][AW-1:0];
      end
      frame_in = frame_ff;
      ptr_in   = ptr_ff;
      state_in = state_ff;
      slot_in  = slot_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_ready;
      rec_in   = rec_ff;
      q_pop    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.kind)
                  KIND_META: begin
                     q_pop = 1'b1;
                     if (q_item.over_cap) begin
                        for (int s = 0; s < SLOT_COUNT; s++) begin
                           ovf_in[s] = 1'b1;
                        end
                     end
                  end
                  KIND_RECT: begin
                     q_pop = 1'b1;
                     for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (!abs_ff[s]) begin
                           if (count_ff[s] >= CW'(MAX_RECTS)) begin
                              ovf_in[s] = 1'b1;
                           end else begin
                              wr_en[s]    = 1'b1;
                              count_in[s] = count_ff[s] + CW'(1);
                           end
                        end
                     end
                  end
                  KIND_ABSENT: begin
                     q_pop = 1'b1;
                     for (int s = 0; s < SLOT_COUNT; s++) begin
                        abs_in[s] = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        frame_in = frame_next;
                        ptr_in   = ptr_next;
                        valid_in = 1'b1;
                        rec_in   = '0;
                        rec_in.slot_index   = 3'(ptr_next);
                        rec_in.frame_number = frame_next;
                        if (q_item.busy) begin
                           rec_in.record_kind = REC_SKIP;
                           rec_in.last        = 1'b1;
                        end else begin
                           rec_in.record_kind = REC_HEADER;
                           rec_in.dirty_since = pub_ff[ptr_next];
                           rec_in.shown_time  = q_item.shown_time;
                           rec_in.coverage_status = abs_ff[ptr_next] ? STAT_ABSENT :
                              (ovf_ff[ptr_next] ? STAT_OVERFLOWED : STAT_COMPLETE);
                           rec_in.rect_total  = 5'(count_ff[ptr_next]);
                           rec_in.last        = (count_ff[ptr_next] == '0);
                           slot_in  = ptr_next;
                           total_in = count_ff[ptr_next];
                           idx_in   = '0;
                           if (count_ff[ptr_next] != '0) begin
                              state_in = ST_READ;
                           end
                           pub_in[ptr_next]   = frame_next;
                           count_in[ptr_next] = '0;
                           ovf_in[ptr_next]   = 1'b0;
                           abs_in[ptr_next]   = 1'b0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               rec_in.record_kind     = REC_RECT;
               rec_in.dirty_since     = '0;
               rec_in.shown_time      = '0;
               rec_in.coverage_status = STAT_COMPLETE;
               rec_in.rect_total      = '0;
               rec_in.rect            = rd_data[slot_ff];
               rec_in.last            = (idx_ff + CW'(1) == total_ff);
               if (idx_ff + CW'(1) == total_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            count_ff[s] <= '0;
            ovf_ff[s]   <= 1'b0;
            abs_ff[s]   <= 1'b0;
            pub_ff[s]   <= '0;
         end
         frame_ff <= '0;
         ptr_ff   <= '0;
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         abs_ff   <= abs_in;
         pub_ff   <= pub_in;
         frame_ff <= frame_in;
         ptr_ff   <= ptr_in;
         state_ff <= state_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      total_ff <= total_in;
      rec_ff   <= rec_in;
   end
endmodule

/* hdl/multi_slot_damage_rect_accumulator.sv */
// Top level of the multi-slot damage rectangle accumulator.
`timescale 1ns / 1ps
// Metadata, absent and rectangle beats enter the two-beat input queue, and the back end
// then applies each to every slot at once; a rectangle goes only to the banks of slots
// not marked absent. A frame-end beat without busy set publishes the chosen slot: each
// stored rectangle of that slot is read from its bank RAM with a registered read before
// it goes to the output register. Beats keep queuing while a publish is walked.
module multi_slot_damage_rect_accumulator import dra_pkg::*; #(
   parameter int SLOT_COUNT = 3,
   parameter int MAX_RECTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dirty_count, move_count, rect_left, rect_top, rect_right, rect_bottom,
   // slot_busy, present_time, acquire_time, zero fill
   input  logic [191:0] req_tdata,
   // kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_index, frame_number, dirty_since, shown_time, coverage_status, rect_total,
   // out_left, out_top, out_right, out_bottom, zero fill
   output logic [191:0] rsp_tdata,
   // record_kind
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   logic       q_valid, q_pop;
   item_type   q_item;
   record_type rec;

   dra_front #(.MAX_RECTS(MAX_RECTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_dirty  (req_tdata[11:0]),
      .in_move   (req_tdata[23:12]),
      .in_rect   (req_tdata[87:24]),
      .in_busy   (req_tdata[88]),
      .in_present(req_tdata[136:89]),
      .in_acquire(req_tdata[184:137]),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   dra_back #(.SLOT_COUNT(SLOT_COUNT), .MAX_RECTS(MAX_RECTS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_rec  (rec)
   );

   assign rsp_tuser = rec.record_kind;
   assign rsp_tlast = rec.last;
   assign rsp_tdata = {6'd0, rec.rect, rec.rect_total, rec.coverage_status,
                       rec.shown_time, rec.dirty_since, rec.frame_number, rec.slot_index};
endmodule
